>>> hw/rtl/seds_pkg.sv
package seds_pkg;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    localparam logic [1:0] SEL_A1 = 2'd0;
    localparam logic [1:0] SEL_B1 = 2'd1;
    localparam logic [1:0] SEL_A2 = 2'd2;
    localparam logic [1:0] SEL_B2 = 2'd3;

    localparam logic [6:0] SCORE_FULL = 7'd100;

    // Control from the sequencer to the cell chain.
    typedef struct packed {
        logic init;   // load row zero into every cell
        logic step;   // feed one A character into the head of the chain
    } t_cell_ctl;

endpackage

>>> hw/rtl/seds_cell.sv
// One column of the edit distance matrix. The cell holds its column's latest
// entry and the entry before it. When its left neighbor has produced a new
// row, the cell computes its own entry of that row in the next cycle and
// hands the row on to its right neighbor.
module seds_cell #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_clear,
    input  logic [DW-1:0] i_init,
    input  logic [7:0]    i_b_char,
    input  logic          i_vld,
    input  logic [7:0]    i_a_char,
    input  logic [DW-1:0] i_left,
    input  logic [DW-1:0] i_diag,
    output logic          o_vld,
    output logic [7:0]    o_a_char,
    output logic [DW-1:0] o_val,
    output logic [DW-1:0] o_prev
);
    logic [DW-1:0] r_val;
    logic [DW-1:0] r_prev;
    logic [7:0]    r_a_char;
    logic          r_vld;
    logic [DW-1:0] n_val;
    logic [DW-1:0] w_m;

    // Minimum of up, left and diagonal, plus one; diagonal on a match.
    always_comb begin
        w_m = (r_val < i_left) ? r_val : i_left;
        w_m = (w_m < i_diag) ? w_m : i_diag;
        n_val = (i_a_char == i_b_char) ? i_diag : (w_m + DW'(1));
    end

    // Row zero on clear; otherwise take one row from the left neighbor.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_val <= i_init;
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_val <= n_val;
                r_prev <= r_val;
                r_a_char <= i_a_char;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_a_char = r_a_char;
    assign o_val = r_val;
    assign o_prev = r_prev;
endmodule

>>> hw/rtl/seds_array.sv
// A chain of cells, one per B column. Rows of the distance matrix enter at
// the head one per cycle and move one cell to the right each cycle, so cell
// j works on row i in the cycle after cell j-1 did.
module seds_array #(
    parameter int N  = 64,
    parameter int DW = 8
) (
    input  logic                i_clk,
    input  seds_pkg::t_cell_ctl i_ctl,
    input  logic [DW-1:0]       i_row_idx,
    input  logic [7:0]          i_a_char,
    input  logic [N-1:0][7:0]   i_b_chars,
    output logic [N-1:0][DW-1:0] o_col
);
    import seds_pkg::*;

    logic [N:0]         w_vld;
    logic [N:0][7:0]    w_a;
    logic [N:0][DW-1:0] w_val;
    logic [N:0][DW-1:0] w_prev;

    // Column zero of row i is i itself, and i - 1 on the row above.
    assign w_vld[0]  = i_ctl.step;
    assign w_a[0]    = i_a_char;
    assign w_val[0]  = i_row_idx;
    assign w_prev[0] = i_row_idx - DW'(1);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            seds_cell #(.DW(DW)) u_cell (
                .i_clk    (i_clk),
                .i_clear  (i_ctl.init),
                .i_init   (DW'(g + 1)),
                .i_b_char (i_b_chars[g]),
                .i_vld    (w_vld[g]),
                .i_a_char (w_a[g]),
                .i_left   (w_val[g]),
                .i_diag   (w_prev[g]),
                .o_vld    (w_vld[g+1]),
                .o_a_char (w_a[g+1]),
                .o_val    (w_val[g+1]),
                .o_prev   (w_prev[g+1])
            );
            assign o_col[g] = w_val[g+1];
        end
    endgenerate
endmodule

>>> hw/rtl/signature_edit_distance_score_top.sv
// Two-part fuzzy signature comparator.
// Command channel: i_start with i_cmd selects load (append i_char_code to
// store i_which_string) or compare (using i_block_size_a/b). A transfer
// happens when i_start is high and o_busy is low.
// A load gives no result, so loads can follow back to back; loads beyond
// MAX_SIG_LEN per store are dropped and raise the overflow flag reported on
// the next compare.
// A compare runs the part-one pair and then the part-two pair through the
// cell chain. A pass feeds one A character per cycle into the chain, then
// waits while the last row travels to the cell of the final B column.
// The divider and then an output state follow. The result is on the o_
// ports with o_done high, and o_busy is low again in that cycle.
// The receiver cannot stall the result. The stores are emptied after each
// compare.
// Reset clears lengths, overflow flag, threshold (to 50) and the sequencer.
// i_cfg_we writes the match threshold at any idle cycle.
module signature_edit_distance_score_top #(
    parameter int MAX_SIG_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic [1:0]  i_which_string,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_block_size_a,
    input  logic [31:0] i_block_size_b,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [6:0]  o_score,
    output logic [6:0]  o_distance_out,
    output logic        o_match_flag,
    output logic        o_sizes_compatible,
    output logic        o_overflow_seen
);
    import seds_pkg::*;

    localparam int AW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    localparam int LW = $clog2(MAX_SIG_LEN + 1);
    localparam int DW = LW;
    localparam int SW = LW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_WAIT = 3'd6;

    // A stores are memories read at one address per cycle; B stores are
    // registers feeding fixed cell columns.
    logic [7:0] r_mem_a1 [MAX_SIG_LEN];
    logic [7:0] r_mem_a2 [MAX_SIG_LEN];
    logic [MAX_SIG_LEN-1:0][7:0] r_b1;
    logic [MAX_SIG_LEN-1:0][7:0] r_b2;
    logic [3:0][LW-1:0] r_len;
    logic r_ovf;
    logic [6:0] r_thr;

    logic [2:0] r_state;
    logic r_pass;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_wcnt;
    logic [7:0] r_achar;
    logic r_compat;
    logic [SW-1:0] r_dsum;
    logic [LW-1:0] r_max;
    logic [SW+6:0] r_den;
    logic [SW+6:0] r_rem;
    logic [SW+6:0] r_quo;
    logic [3:0] r_dcnt;
    logic r_ovf_hold;

    t_cell_ctl w_ctl;
    logic [MAX_SIG_LEN-1:0][DW-1:0] w_col;
    logic [LW-1:0] w_m;
    logic [LW-1:0] w_n;
    logic [LW-1:0] w_n_m1;
    logic [LW-1:0] w_dist;
    logic [LW-1:0] w_max_mn;
    logic [LW-1:0] w_max_all;
    logic w_accept;

    assign w_accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);
    assign w_m = r_pass ? r_len[SEL_A2] : r_len[SEL_A1];
    assign w_n = r_pass ? r_len[SEL_B2] : r_len[SEL_B1];

    // Distance of the current pair: the final B column's entry of the last
    // row, or the A length when B is empty.
    assign w_n_m1 = w_n - LW'(1);
    assign w_dist = (w_n == '0) ? w_m : w_col[w_n_m1[AW-1:0]];

    // Longest part seen so far, including this pass's pair.
    assign w_max_mn = (w_m > w_n) ? w_m : w_n;
    assign w_max_all = (w_max_mn > r_max) ? w_max_mn : r_max;

    assign w_ctl.init = (r_state == ST_INIT);
    assign w_ctl.step = (r_state == ST_ROW) && (r_i <= w_m) && (r_i != '0);

    seds_array #(.N(MAX_SIG_LEN), .DW(DW)) u_array (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_row_idx (DW'(r_i)),
        .i_a_char  (r_achar),
        .i_b_chars (r_pass ? r_b2 : r_b1),
        .o_col     (w_col)
    );

    // Store writes and A-character read port.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_cmd == CMD_LOAD && r_len[i_which_string] < LW'(MAX_SIG_LEN)) begin
            case (i_which_string)
                SEL_A1: r_mem_a1[r_len[SEL_A1][AW-1:0]] <= i_char_code;
                SEL_B1: r_b1[r_len[SEL_B1][AW-1:0]] <= i_char_code;
                SEL_A2: r_mem_a2[r_len[SEL_A2][AW-1:0]] <= i_char_code;
                default: r_b2[r_len[SEL_B2][AW-1:0]] <= i_char_code;
            endcase
        end
        if (r_pass) begin
            r_achar <= r_mem_a2[r_i[AW-1:0]];
        end else begin
            r_achar <= r_mem_a1[r_i[AW-1:0]];
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 7'd50;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    logic [33:0] w_a2;
    logic [33:0] w_b2;
    assign w_a2 = {1'b0, i_block_size_a, 1'b0};
    assign w_b2 = {1'b0, i_block_size_b, 1'b0};

    // Sequencer: counts loads when idle; on a compare, rows of pass one, rows of pass two, then score and divide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_pass <= 1'b0;
            r_i <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_cmd == CMD_LOAD) begin
                        if (r_len[i_which_string] < LW'(MAX_SIG_LEN)) begin
                            r_len[i_which_string] <= r_len[i_which_string] + LW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else if (w_accept) begin
                        r_compat <= (i_block_size_a == i_block_size_b)
                            || ({2'b0, i_block_size_a} == w_b2)
                            || (w_a2 == {2'b0, i_block_size_b});
                        r_dsum <= '0;
                        r_pass <= 1'b0;
                        r_max <= '0;
                        r_ovf_hold <= r_ovf;
                        r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    // Row zero loaded; A char 0 is being read.
                    r_i <= LW'(1);
                    r_state <= ST_ROW;
                end
                ST_ROW: begin
                    if (r_i >= w_m) begin
                        r_wcnt <= LW'(1);
                        r_state <= ST_WAIT;
                    end else begin
                        r_i <= r_i + LW'(1);
                    end
                end
                ST_WAIT: begin
                    // Hold until the last row has reached the final B column.
                    if (r_wcnt >= w_n) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_wcnt <= r_wcnt + LW'(1);
                    end
                end
                ST_DONE: begin
                    r_dsum <= r_dsum + SW'(w_dist);
                    r_max <= w_max_all;
                    r_i <= '0;
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        r_state <= ST_INIT;
                    end else begin
                        r_state <= ST_DIV;
                        r_dcnt <= '0;
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd8) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    o_done <= 1'b1;
                    r_len <= '0;
                    r_ovf <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Restoring divider: (dsum*100) / (2*max+1), two quotient bits a cycle.
    logic [SW+6:0] w_prod;
    logic [SW+6:0] n_rem;
    logic [SW+6:0] n_quo;
    assign w_prod = (SW+7)'(r_dsum) * (SW+7)'(100);

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[SW+5:0], n_quo[SW+6]};
            n_quo = {n_quo[SW+5:0], 1'b0};
            if (n_rem >= r_den) begin
                n_rem = n_rem - r_den;
                n_quo[0] = 1'b1;
            end
        end
    end

    // Eight steps of two bits each cover the whole dividend.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_dcnt == 4'd0) begin
            r_den <= (SW+7)'({r_max, 1'b1});
            r_rem <= '0;
            r_quo <= w_prod;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Result formatting.
    logic [6:0] w_score;
    always_comb begin
        if (!r_compat) begin
            w_score = '0;
        end else if (r_quo >= (SW+7)'(100)) begin
            w_score = '0;
        end else begin
            w_score = SCORE_FULL - r_quo[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            o_score <= w_score;
            o_distance_out <= SCORE_FULL - w_score;
            o_match_flag <= r_compat && (w_score >= r_thr);
            o_sizes_compatible <= r_compat;
            o_overflow_seen <= r_ovf_hold;
        end
    end
endmodule
